[rtl/truncation_selection_mu_lambda_macros.svh]
// assertion macros for the truncation selection block
`ifndef TRUNCATION_SELECTION_MU_LAMBDA_MACROS_SVH
`define TRUNCATION_SELECTION_MU_LAMBDA_MACROS_SVH

// same-cycle implication, disabled in reset
`define TSML_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TSML_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tsml_pkg.sv]
// shared constants, codes and control structs of the truncation selection block
`timescale 1ns / 1ps
package tsml_pkg;

  localparam int MaxParents   = 32;
  localparam int MaxOffspring = 64;
  localparam int FitBits      = 32;

  localparam int PIdxW    = $clog2(MaxParents);
  localparam int OIdxW    = $clog2(MaxOffspring);
  localparam int MuW      = $clog2(MaxParents + 1);
  localparam int LamW     = $clog2(MaxOffspring + 1);
  localparam int EntryW   = 6;
  localparam int SlotW    = 5;
  localparam int SrcW     = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int PCountW  = 6;
  localparam int OCountW  = 7;

  typedef enum logic [1:0] {
    OP_LOAD_PARENT    = 2'd0,
    OP_LOAD_OFFSPRING = 2'd1,
    OP_RUN            = 2'd2,
    OP_NONE           = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEEP_PARENTS    = 2'd0,
    REG_MINIMIZE        = 2'd1,
    REG_PARENT_COUNT    = 2'd2,
    REG_OFFSPRING_COUNT = 2'd3
  } reg_e;

  // commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic start;
    logic grp;       // 0 offspring, 1 parents
    logic rk_load;
    logic rk_hold;
    logic rk_scan;
    logic rk_write;
    logic mg_idx;
    logic mg_fit;
    logic mg_cmp;
    logic em_pos;
    logic em_idx;
    logic em_fit;
    logic em_load;
    logic err_load;
  } tsml_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic run_req;
    logic mu_zero;
    logic comma_err;
    logic lam_zero;
    logic keep;
    logic scan_done;
    logic rank_done;
    logic merge_more;
    logic emit_done;
    logic out_free;
  } tsml_sts_t;

  // strictly better fitness, signed compare
  function automatic logic fit_better(logic [FitBits-1:0] a, logic [FitBits-1:0] b,
                                      logic minimize);
    fit_better = minimize ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
  endfunction

endpackage

[rtl/tsml_ifs.sv]
// request, result and register write channels of the truncation selection block
`timescale 1ns / 1ps

interface tsml_in_if import tsml_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [EntryW-1:0]         entry_index;
  logic signed [FitBits-1:0] fitness;
  modport source (output valid, operation, entry_index, fitness, input ready);
  modport sink   (input valid, operation, entry_index, fitness, output ready);
endinterface

interface tsml_out_if import tsml_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SlotW-1:0]          slot;
  logic                      from_offspring;
  logic [SrcW-1:0]           source_index;
  logic signed [FitBits-1:0] survivor_fitness;
  logic                      status;
  logic                      last;
  modport source (output valid, slot, from_offspring, source_index, survivor_fitness,
                  status, last, input ready);
  modport sink   (input valid, slot, from_offspring, source_index, survivor_fitness,
                  status, last, output ready);
endinterface

interface tsml_cfg_if import tsml_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tsml_datapath.sv]
// fitness stores, rank tables, counters and result register
`timescale 1ns / 1ps
module tsml_datapath import tsml_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsml_cmd_t           cmd_i,
  output tsml_sts_t           sts_o,
  input  logic                in_take_i,
  input  logic [1:0]          in_op_i,
  input  logic [EntryW-1:0]   in_idx_i,
  input  logic [FitBits-1:0]  in_fit_i,
  input  logic                cfg_take_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [SlotW-1:0]    out_slot_o,
  output logic                out_from_off_o,
  output logic [SrcW-1:0]     out_src_o,
  output logic [FitBits-1:0]  out_fit_o,
  output logic                out_status_o,
  output logic                out_last_o
);

  // configuration registers
  logic               keep_q, min_q;
  logic [PCountW-1:0] pcount_q;
  logic [OCountW-1:0] ocount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q   <= 1'b1;
      min_q    <= 1'b0;
      pcount_q <= PCountW'(1);
      ocount_q <= '0;
    end else if (cfg_take_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_KEEP_PARENTS:    keep_q   <= cfg_data_i[0];
        REG_MINIMIZE:        min_q    <= cfg_data_i[0];
        REG_PARENT_COUNT:    pcount_q <= cfg_data_i[PCountW-1:0];
        REG_OFFSPRING_COUNT: ocount_q <= cfg_data_i[OCountW-1:0];
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [MuW-1:0]  mu;
  logic [LamW-1:0] lam, n;
  assign mu  = (pcount_q > PCountW'(MaxParents)) ? MuW'(MaxParents) : MuW'(pcount_q);
  assign lam = (ocount_q > OCountW'(MaxOffspring)) ? LamW'(MaxOffspring) : LamW'(ocount_q);
  assign n   = cmd_i.grp ? LamW'(mu) : lam;

  // storage
  logic [FitBits-1:0] par_mem   [MaxParents];
  logic [FitBits-1:0] off_mem   [MaxOffspring];
  logic [OIdxW-1:0]   orank_mem [MaxOffspring];
  logic [PIdxW-1:0]   prank_mem [MaxParents];
  logic [PIdxW-1:0]   ppos_mem  [MaxParents];

  logic [FitBits-1:0] par_rd_q, off_rd_q;
  logic [OIdxW-1:0]   orank_rd_q;
  logic [PIdxW-1:0]   prank_rd_q, ppos_rd_q;

  // counters and working registers
  logic [LamW-1:0]    i_q, k_q, oi_q;
  logic [OIdxW-1:0]   cnt_q;
  logic [FitBits-1:0] fi_q;
  logic [MuW-1:0]     j_q, picks_q, r_q, s_q;
  logic [OIdxW-1:0]   pos_q;
  logic               take_off_q;

  logic [PIdxW-1:0]   par_addr, prank_addr, wr_pos;
  logic [OIdxW-1:0]   off_addr, orank_addr, pos_c;
  logic [LamW-1:0]    k_nxt;
  logic [FitBits-1:0] scan_fit;
  logic               beat, take_c, out_free;

  assign k_nxt    = k_q + LamW'(1);
  assign pos_c    = keep_q ? OIdxW'(ppos_rd_q) : OIdxW'(s_q);
  assign take_c   = !keep_q || (MuW'(ppos_rd_q) < r_q);
  assign wr_pos   = PIdxW'(mu - MuW'(1) - MuW'(cnt_q));
  assign scan_fit = cmd_i.grp ? par_rd_q : off_rd_q;
  assign beat     = (k_q != i_q) && (fit_better(scan_fit, fi_q, min_q) ||
                    ((scan_fit == fi_q) && (k_q < i_q)));
  assign out_free = !out_valid_o || out_ready_i;

  // read address selection
  always_comb begin
    par_addr   = '0;
    off_addr   = '0;
    orank_addr = '0;
    prank_addr = '0;
    if (cmd_i.rk_load) begin
      par_addr = PIdxW'(i_q);
      off_addr = OIdxW'(i_q);
    end else if (cmd_i.rk_scan) begin
      par_addr = PIdxW'(k_nxt);
      off_addr = OIdxW'(k_nxt);
    end else if (cmd_i.mg_idx) begin
      orank_addr = OIdxW'(oi_q);
      prank_addr = PIdxW'(j_q - MuW'(1));
    end else if (cmd_i.mg_fit) begin
      par_addr = prank_rd_q;
      off_addr = orank_rd_q;
    end else if (cmd_i.em_idx) begin
      par_addr   = PIdxW'(s_q);
      orank_addr = pos_c;
    end else if (cmd_i.em_fit || cmd_i.em_load) begin
      par_addr   = PIdxW'(s_q);
      orank_addr = pos_q;
      off_addr   = orank_rd_q;
    end
  end

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (in_take_i && (op_e'(in_op_i) == OP_LOAD_PARENT) && (in_idx_i < EntryW'(MaxParents)))
      par_mem[PIdxW'(in_idx_i)] <= in_fit_i;
    if (in_take_i && (op_e'(in_op_i) == OP_LOAD_OFFSPRING))
      off_mem[OIdxW'(in_idx_i)] <= in_fit_i;
    if (cmd_i.rk_write && !cmd_i.grp)
      orank_mem[cnt_q] <= OIdxW'(i_q);
    if (cmd_i.rk_write && cmd_i.grp) begin
      prank_mem[wr_pos]       <= PIdxW'(i_q);
      ppos_mem[PIdxW'(i_q)]   <= wr_pos;
    end
    par_rd_q   <= par_mem[par_addr];
    off_rd_q   <= off_mem[off_addr];
    orank_rd_q <= orank_mem[orank_addr];
    prank_rd_q <= prank_mem[prank_addr];
    if (cmd_i.em_pos) ppos_rd_q <= ppos_mem[PIdxW'(s_q)];
  end

  // ranking counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      k_q   <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.start) i_q <= '0;
      else if (cmd_i.rk_write) i_q <= sts_o.rank_done ? '0 : i_q + LamW'(1);
      if (cmd_i.rk_hold) begin
        k_q   <= '0;
        cnt_q <= '0;
      end else if (cmd_i.rk_scan) begin
        k_q   <= k_nxt;
        cnt_q <= cnt_q + OIdxW'(beat);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_hold) fi_q <= cmd_i.grp ? par_rd_q : off_rd_q;
  end

  // merge and emit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oi_q       <= '0;
      j_q        <= '0;
      picks_q    <= '0;
      r_q        <= '0;
      s_q        <= '0;
      pos_q      <= '0;
      take_off_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        oi_q    <= '0;
        j_q     <= mu;
        picks_q <= '0;
        r_q     <= '0;
        s_q     <= '0;
      end else if (cmd_i.mg_cmp) begin
        picks_q <= picks_q + MuW'(1);
        if (!fit_better(par_rd_q, off_rd_q, min_q)) begin
          r_q  <= r_q + MuW'(1);
          oi_q <= oi_q + LamW'(1);
        end else begin
          j_q <= j_q - MuW'(1);
        end
      end else if (cmd_i.em_load && out_free) begin
        s_q <= s_q + MuW'(1);
      end
      if (cmd_i.em_idx) begin
        pos_q      <= pos_c;
        take_off_q <= take_c;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((cmd_i.em_load || cmd_i.err_load) && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_load && out_free) begin
      out_slot_o     <= SlotW'(s_q);
      out_from_off_o <= take_off_q;
      out_src_o      <= take_off_q ? SrcW'(orank_rd_q) : SrcW'(s_q);
      out_fit_o      <= take_off_q ? off_rd_q : par_rd_q;
      out_status_o   <= 1'b0;
      out_last_o     <= sts_o.emit_done;
    end else if (cmd_i.err_load && out_free) begin
      out_slot_o     <= '0;
      out_from_off_o <= 1'b0;
      out_src_o      <= '0;
      out_fit_o      <= '0;
      out_status_o   <= 1'b1;
      out_last_o     <= 1'b1;
    end
  end

  // status to controller
  assign sts_o.run_req    = in_take_i && (op_e'(in_op_i) == OP_RUN);
  assign sts_o.mu_zero    = (mu == '0);
  assign sts_o.comma_err  = !keep_q && (LamW'(mu) > lam);
  assign sts_o.lam_zero   = (lam == '0);
  assign sts_o.keep       = keep_q;
  assign sts_o.scan_done  = (k_q == n - LamW'(1));
  assign sts_o.rank_done  = (i_q == n - LamW'(1));
  assign sts_o.merge_more = (picks_q < mu) && (oi_q < lam);
  assign sts_o.emit_done  = (s_q == mu - MuW'(1));
  assign sts_o.out_free   = out_free;

endmodule

[rtl/tsml_ctrl.sv]
// sequencing state machine: rank, merge and emit phases
`timescale 1ns / 1ps
module tsml_ctrl import tsml_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tsml_sts_t sts_i,
  output tsml_cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_RK_LOAD = 14'b00000000000010,
    S_RK_HOLD = 14'b00000000000100,
    S_RK_SCAN = 14'b00000000001000,
    S_RK_WRT  = 14'b00000000010000,
    S_MG_CHK  = 14'b00000000100000,
    S_MG_IDX  = 14'b00000001000000,
    S_MG_FIT  = 14'b00000010000000,
    S_MG_CMP  = 14'b00000100000000,
    S_EM_POS  = 14'b00001000000000,
    S_EM_IDX  = 14'b00010000000000,
    S_EM_FIT  = 14'b00100000000000,
    S_EM_LOAD = 14'b01000000000000,
    S_ERR     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   grp_q, grp_d;

  // next state
  always_comb begin
    state_d = state_q;
    grp_d   = grp_q;
    unique case (state_q)
      S_IDLE: begin
        if (sts_i.run_req) begin
          if (sts_i.mu_zero) begin
            state_d = S_IDLE;
          end else if (sts_i.comma_err) begin
            state_d = S_ERR;
          end else begin
            grp_d   = sts_i.lam_zero;
            state_d = S_RK_LOAD;
          end
        end
      end
      S_RK_LOAD: state_d = S_RK_HOLD;
      S_RK_HOLD: state_d = S_RK_SCAN;
      S_RK_SCAN: if (sts_i.scan_done) state_d = S_RK_WRT;
      S_RK_WRT: begin
        if (!sts_i.rank_done) begin
          state_d = S_RK_LOAD;
        end else if (grp_q) begin
          state_d = S_MG_CHK;
        end else if (sts_i.keep) begin
          grp_d   = 1'b1;
          state_d = S_RK_LOAD;
        end else begin
          state_d = S_EM_POS;
        end
      end
      S_MG_CHK:  state_d = sts_i.merge_more ? S_MG_IDX : S_EM_POS;
      S_MG_IDX:  state_d = S_MG_FIT;
      S_MG_FIT:  state_d = S_MG_CMP;
      S_MG_CMP:  state_d = S_MG_CHK;
      S_EM_POS:  state_d = S_EM_IDX;
      S_EM_IDX:  state_d = S_EM_FIT;
      S_EM_FIT:  state_d = S_EM_LOAD;
      S_EM_LOAD: if (sts_i.out_free) state_d = sts_i.emit_done ? S_IDLE : S_EM_POS;
      S_ERR:     if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
    end
  end

  // command decode
  assign cmd_o.in_ready = (state_q == S_IDLE);
  assign cmd_o.start    = (state_q == S_IDLE) && sts_i.run_req;
  assign cmd_o.grp      = grp_q;
  assign cmd_o.rk_load  = (state_q == S_RK_LOAD);
  assign cmd_o.rk_hold  = (state_q == S_RK_HOLD);
  assign cmd_o.rk_scan  = (state_q == S_RK_SCAN);
  assign cmd_o.rk_write = (state_q == S_RK_WRT);
  assign cmd_o.mg_idx   = (state_q == S_MG_IDX);
  assign cmd_o.mg_fit   = (state_q == S_MG_FIT);
  assign cmd_o.mg_cmp   = (state_q == S_MG_CMP);
  assign cmd_o.em_pos   = (state_q == S_EM_POS);
  assign cmd_o.em_idx   = (state_q == S_EM_IDX);
  assign cmd_o.em_fit   = (state_q == S_EM_FIT);
  assign cmd_o.em_load  = (state_q == S_EM_LOAD);
  assign cmd_o.err_load = (state_q == S_ERR);

endmodule

[rtl/truncation_selection_mu_lambda.sv]
// top level of the truncation survivor selection block
`timescale 1ns / 1ps
`include "truncation_selection_mu_lambda_macros.svh"
// Truncation survivor selection, mu plus lambda or mu comma lambda. Load requests
// (parent or offspring fitness) are taken one per cycle with no result. A run
// request ranks the offspring and, in mu plus lambda mode, then the parents by
// pairwise counting on one read port of each fitness memory: each entry is loaded,
// held, scanned against all n entries and its rank written. Merge steps (at most
// mu of them) each check, fetch ranked indices, fetch fitness and compare; each
// result, one per parent slot, is emitted by position, index, fitness and load.
// The input side is held off until the last result of a run is registered.
// Memories are not cleared: a run that reads an entry never loaded gives an undefined fitness there.
module truncation_selection_mu_lambda import tsml_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tsml_in_if.sink    in_i,
  tsml_cfg_if.sink   cfg_i,
  tsml_out_if.source out_o
);

  tsml_cmd_t cmd;
  tsml_sts_t sts;
  logic      in_take, cfg_take;

  // handshakes
  assign in_i.ready  = cmd.in_ready;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_take    = cfg_i.valid;

  tsml_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tsml_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_take_i      (in_take),
    .in_op_i        (in_i.operation),
    .in_idx_i       (in_i.entry_index),
    .in_fit_i       (in_i.fitness),
    .cfg_take_i     (cfg_take),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_slot_o     (out_o.slot),
    .out_from_off_o (out_o.from_offspring),
    .out_src_o      (out_o.source_index),
    .out_fit_o      (out_o.survivor_fitness),
    .out_status_o   (out_o.status),
    .out_last_o     (out_o.last)
  );

  // error result stands alone
  `TSML_ASSERT_IMP(a_err_alone, clk_i, rst_ni, out_o.valid && out_o.status, out_o.last && !out_o.from_offspring, "error result not single")
  // a run request with parent slots in use closes the input side
  `TSML_ASSERT_NXT(a_run_busy, clk_i, rst_ni, sts.run_req && !sts.mu_zero, !in_i.ready, "input open during run")
  // comma mode only hands out offspring
  `TSML_ASSERT_IMP(a_comma_off, clk_i, rst_ni, out_o.valid && !out_o.status && !sts.keep, out_o.from_offspring, "comma result from parent")

endmodule

[sim/tsml_tb_ifs.sv]
// testbench-side notes: channels come from the rtl interface file
`timescale 1ns / 1ps
package tsml_tb_pkg;
  import tsml_pkg::*;

  // one expected survivor record
  typedef struct packed {
    logic [SlotW-1:0]          slot;
    logic                      from_offspring;
    logic [SrcW-1:0]           source_index;
    logic signed [FitBits-1:0] survivor_fitness;
    logic                      status;
    logic                      last;
  } survivor_t;
endpackage

[sim/truncation_selection_mu_lambda_tb.sv]
// self-checking testbench of the truncation survivor selection block
`timescale 1ns / 1ps
module truncation_selection_mu_lambda_tb;
  import tsml_pkg::*;
  import tsml_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tsml_in_if  in_ch ();
  tsml_out_if out_ch ();
  tsml_cfg_if cfg_ch ();

  truncation_selection_mu_lambda i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .cfg_i (cfg_ch.sink),
    .out_o (out_ch.source)
  );

  // predictor state
  logic                      keep_q;
  logic                      min_q;
  int unsigned               mu_q;
  int unsigned               lam_q;
  logic signed [FitBits-1:0] par_fit[MaxParents];
  logic signed [FitBits-1:0] off_fit[MaxOffspring];
  survivor_t                 survivors_due[$];

  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  longint cycle_cnt = 0;

  initial forever #6 clk_i = ~clk_i;

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd8000000) begin
      $display("FAIL truncation_selection_mu_lambda");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit is_better(logic signed [FitBits-1:0] a, logic signed [FitBits-1:0] b);
    return min_q ? (a < b) : (a > b);
  endfunction

  function automatic bit wins(logic signed [FitBits-1:0] a, int ia,
                              logic signed [FitBits-1:0] b, int ib);
    if (is_better(a, b)) return 1;
    if (is_better(b, a)) return 0;
    return ia < ib;
  endfunction

  // expected survivors of one run request
  task automatic predict_survivors();
    int unsigned mu, lam, r, picks, j, oi, pos;
    int off_order[MaxOffspring];
    int par_worst[MaxParents];
    int par_pos[MaxParents];
    survivor_t s;
    mu  = (mu_q > MaxParents) ? MaxParents : mu_q;
    lam = (lam_q > MaxOffspring) ? MaxOffspring : lam_q;
    if (mu == 0) return;
    for (int i = 0; i < lam; i++) begin
      r = 0;
      for (int k = 0; k < lam; k++)
        if (k != i && wins(off_fit[k], k, off_fit[i], i)) r++;
      off_order[r] = i;
    end
    if (!keep_q) begin
      if (mu > lam) begin
        s = '0;
        s.status = 1'b1;
        s.last = 1'b1;
        survivors_due.push_back(s);
        return;
      end
      for (int i = 0; i < mu; i++) begin
        s = '0;
        s.slot = SlotW'(i);
        s.from_offspring = 1'b1;
        s.source_index = SrcW'(off_order[i]);
        s.survivor_fitness = off_fit[off_order[i]];
        s.last = (i + 1 == mu);
        survivors_due.push_back(s);
      end
      return;
    end
    for (int i = 0; i < mu; i++) begin
      r = 0;
      for (int k = 0; k < mu; k++)
        if (k != i && wins(par_fit[k], k, par_fit[i], i)) r++;
      par_pos[i] = mu - 1 - r;
      par_worst[mu - 1 - r] = i;
    end
    // offspring count among the best mu of the union
    j = mu; oi = 0; picks = 0; r = 0;
    while (picks < mu && oi < lam) begin
      if (!is_better(par_fit[par_worst[j-1]], off_fit[off_order[oi]])) begin
        r++; oi++;
      end else begin
        j--;
      end
      picks++;
    end
    for (int i = 0; i < mu; i++) begin
      s = '0;
      s.slot = SlotW'(i);
      pos = par_pos[i];
      if (pos < r) begin
        s.from_offspring = 1'b1;
        s.source_index = SrcW'(off_order[pos]);
        s.survivor_fitness = off_fit[off_order[pos]];
      end else begin
        s.source_index = SrcW'(i);
        s.survivor_fitness = par_fit[i];
      end
      s.last = (i + 1 == mu);
      survivors_due.push_back(s);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    survivor_t got, want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.slot, out_ch.from_offspring, out_ch.source_index,
                out_ch.survivor_fitness, out_ch.status, out_ch.last};
        if (survivors_due.size() == 0) begin
          report("result with none expected");
        end else begin
          want = survivors_due.pop_front();
          if (got.slot !== want.slot)
            report($sformatf("slot %0d want %0d", got.slot, want.slot));
          if (got.from_offspring !== want.from_offspring)
            report($sformatf("from_offspring %0b want %0b", got.from_offspring,
                             want.from_offspring));
          if (got.source_index !== want.source_index)
            report($sformatf("source_index %0d want %0d", got.source_index,
                             want.source_index));
          if (got.survivor_fitness !== want.survivor_fitness)
            report($sformatf("fitness %0h want %0h", got.survivor_fitness,
                             want.survivor_fitness));
          if (got.status !== want.status)
            report($sformatf("status %0b want %0b", got.status, want.status));
          if (got.last !== want.last)
            report($sformatf("last %0b want %0b", got.last, want.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one request and update the predictor on acceptance
  // valid stays high after acceptance so that requests follow back to back;
  // idle cycles and register writes drop it
  task automatic send_request(input op_e op, input int idx, input logic [FitBits-1:0] fit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx[EntryW-1:0];
    in_ch.fitness     <= fit;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    case (op)
      OP_LOAD_PARENT: if (idx < MaxParents) begin
        par_fit[idx] = fit;
      end
      OP_LOAD_OFFSPRING: if (idx < MaxOffspring) begin
        off_fit[idx] = fit;
      end
      OP_RUN: predict_survivors();
      default: ;
    endcase
  endtask

  // wait for quiet, then write one register
  task automatic write_reg(input reg_e idx, input int val);
    in_ch.valid <= 1'b0;
    while (survivors_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_KEEP_PARENTS:    keep_q = val[0];
      REG_MINIMIZE:        min_q = val[0];
      REG_PARENT_COUNT:    mu_q = val & 8'h3f;
      REG_OFFSPRING_COUNT: lam_q = val & 8'h7f;
      default: ;
    endcase
  endtask

  task automatic set_mode(input int kp, input int mn, input int mu, input int lam);
    write_reg(REG_KEEP_PARENTS, kp);
    write_reg(REG_MINIMIZE, mn);
    write_reg(REG_PARENT_COUNT, mu);
    write_reg(REG_OFFSPRING_COUNT, lam);
  endtask

  function automatic logic [FitBits-1:0] rand_fit();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      default: return $urandom();
    endcase
  endfunction

  // fill every entry that a run of the current counts reads
  task automatic fill_stores(input int mu, input int lam);
    for (int i = 0; i < mu && i < MaxParents; i++)
      send_request(OP_LOAD_PARENT, i, rand_fit());
    for (int i = 0; i < lam && i < MaxOffspring; i++)
      send_request(OP_LOAD_OFFSPRING, i, rand_fit());
  endtask

  // directed: extremes, ties, comma error, ignored requests, zero mu
  task automatic test_directed();
    send_request(OP_LOAD_PARENT, 0, 32'h7fff_ffff);
    send_request(OP_RUN, 0, 0);                       // plus with no offspring
    set_mode(1, 0, 3, 2);
    send_request(OP_LOAD_PARENT, 1, 32'h8000_0000);
    send_request(OP_LOAD_PARENT, 2, 32'h8000_0000);   // equal parents
    send_request(OP_LOAD_OFFSPRING, 0, 32'h8000_0000); // ties a parent
    send_request(OP_LOAD_OFFSPRING, 1, 32'h0001_0000);
    send_request(OP_LOAD_PARENT, 40, 32'h1234_5678);  // out of range, ignored
    send_request(OP_NONE, 63, 32'hffff_ffff);         // ignored
    send_request(OP_RUN, 0, 0);
    write_reg(REG_MINIMIZE, 1);
    send_request(OP_RUN, 0, 0);
    write_reg(REG_KEEP_PARENTS, 0);
    send_request(OP_RUN, 0, 0);                       // comma error
    write_reg(REG_PARENT_COUNT, 2);
    send_request(OP_RUN, 0, 0);
    write_reg(REG_PARENT_COUNT, 0);
    send_request(OP_RUN, 0, 0);                       // no result
    // largest sizes once, counts above range clamp
    set_mode(1, 0, 63, 127);
    fill_stores(MaxParents, MaxOffspring);
    send_request(OP_RUN, 0, 0);
    write_reg(REG_KEEP_PARENTS, 0);
    send_request(OP_RUN, 0, 0);
  endtask

  // random phases: small sizes, load sets then run
  task automatic test_random(input int n_items);
    int sent, mu, lam;
    sent = 0;
    while (sent < n_items) begin
      mu  = $urandom_range(1, 6);
      lam = $urandom_range(0, 9);
      set_mode($urandom_range(1), $urandom_range(1), mu, lam);
      fill_stores(mu, lam);
      sent += mu + lam;
      repeat ($urandom_range(1, 3)) begin
        // random reloads, with some noise
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(5))
            0: send_request(OP_NONE, $urandom_range(63), $urandom());
            1: send_request(OP_LOAD_PARENT, $urandom_range(32, 63), $urandom());
            2: send_request(OP_LOAD_OFFSPRING, $urandom_range(lam > 0 ? lam - 1 : 0), rand_fit());
            default: send_request(OP_LOAD_PARENT, $urandom_range(mu - 1), rand_fit());
          endcase
          sent++;
        end
        if (lam == 0) fill_stores(0, 1);
        send_request(OP_RUN, $urandom_range(63), $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    keep_q = 1; min_q = 0; mu_q = 1; lam_q = 0;
    in_ch.valid = 0; in_ch.operation = OP_NONE; in_ch.entry_index = 0; in_ch.fitness = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_KEEP_PARENTS; cfg_ch.data = 0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 37; recv_idle_pct = 66;
    test_random(100);
    send_idle_pct = 66; recv_idle_pct = 37;
    test_random(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(100);
    in_ch.valid <= 1'b0;
    while (survivors_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && survivors_due.size() == 0) begin
      $display("PASS truncation_selection_mu_lambda");
    end else begin
      $display("FAIL truncation_selection_mu_lambda");
    end
    $finish;
  end
endmodule
